>>> src/stgl_pkg.sv
// Shared types and constants for the source text to grid loader.
package stgl_pkg;

  localparam int AXES = 4;
  localparam int QDEPTH = 2;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SP = 8'h20;

  localparam logic [3:0] PAGE_MIN_DIMS = 4'd3;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_EOF  = 1'b1;

  localparam logic OUT_CELL   = 1'b0;
  localparam logic OUT_EXTENT = 1'b1;

  localparam logic [2:0] REG_START_X = 3'd0;
  localparam logic [2:0] REG_START_Y = 3'd1;
  localparam logic [2:0] REG_START_Z = 3'd2;
  localparam logic [2:0] REG_START_W = 3'd3;
  localparam logic [2:0] REG_BINARY  = 3'd4;
  localparam logic [2:0] REG_DIMS    = 3'd5;

  typedef enum logic [2:0] {
    OP_ORD,
    OP_LINE,
    OP_FF,
    OP_VT,
    OP_EOF
  } op_kind_t;

  typedef enum logic [1:0] {
    BRK_NONE,
    BRK_FF,
    BRK_VT
  } brk_t;

  typedef enum logic [1:0] {
    AX_HOLD,
    AX_BUMP,
    AX_BACK,
    AX_LOAD
  } ax_act_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] value;
  } op_t;

  typedef struct packed {
    logic                 kind;
    logic [3:0][31:0]     coord;
    logic [7:0]           value;
    logic [3:0][31:0]     extent;
  } res_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  axis;
    logic [31:0] value;
  } start_load_t;

endpackage

>>> src/stgl_fifo.sv
// Two-entry word queue used between the loader stages.
module stgl_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  import stgl_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  logic [WIDTH-1:0] mem [QDEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (PW+1)'(QDEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  // depth is a power of two, so the pointers wrap on their own
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= din;
  end

endmodule

>>> src/stgl_front.sv
// Front stage: classifies source bytes into cursor operations.
module stgl_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic          kind,
  input  logic [7:0]    byte_value,
  input  logic          binary_mode,
  input  logic [3:0]    dimension_count,
  output logic          op_push,
  output stgl_pkg::op_t op
);
  import stgl_pkg::*;

  brk_t last_break;
  brk_t last_break_next;
  logic after_cr;
  logic after_cr_next;
  logic pages;
  logic is_lf;
  logic is_cr;
  logic is_ff;
  logic is_vt;

  assign pages = (dimension_count == 4'd0) || (dimension_count >= PAGE_MIN_DIMS);
  assign is_lf = (byte_value == CH_LF);
  assign is_cr = (byte_value == CH_CR);
  assign is_ff = (byte_value == CH_FF);
  assign is_vt = (byte_value == CH_VT);

  always_comb begin
    last_break_next = last_break;
    after_cr_next   = after_cr;
    op_push         = 1'b0;
    op.kind         = OP_ORD;
    op.value        = byte_value;
    if (take) begin
      if (kind == KIND_EOF) begin
        op_push         = 1'b1;
        op.kind         = OP_EOF;
        last_break_next = BRK_NONE;
        after_cr_next   = 1'b0;
      end else if (after_cr && is_lf) begin
        // LF right after CR: one line break only
        after_cr_next = 1'b0;
      end else begin
        after_cr_next = 1'b0;
        if (!binary_mode && (is_lf || is_cr)) begin
          after_cr_next = is_cr;
          if (last_break == BRK_NONE) begin
            op_push = 1'b1;
            op.kind = OP_LINE;
          end
        end else if (!binary_mode && is_ff) begin
          if (pages) begin
            op_push         = 1'b1;
            op.kind         = OP_FF;
            last_break_next = BRK_FF;
          end
        end else if (!binary_mode && is_vt) begin
          if (pages) begin
            op_push         = 1'b1;
            op.kind         = OP_VT;
            last_break_next = BRK_VT;
          end
        end else begin
          op_push = 1'b1;
          op.kind = OP_ORD;
          if (is_ff) begin
            last_break_next = BRK_FF;
          end else if (is_vt) begin
            last_break_next = BRK_VT;
          end else begin
            last_break_next = BRK_NONE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_break <= BRK_NONE;
      after_cr   <= 1'b0;
    end else begin
      last_break <= last_break_next;
      after_cr   <= after_cr_next;
    end
  end

endmodule

>>> src/stgl_back.sv
// Back stage: cursor and high-water registers, builds result words.
module stgl_back #(
  parameter int COORD_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  op_valid,
  input  stgl_pkg::op_t         op,
  output logic                  op_pop,
  input  logic [3:0][31:0]      start,
  input  stgl_pkg::start_load_t load,
  output logic                  res_push,
  output stgl_pkg::res_t        res,
  input  logic                  res_full
);
  import stgl_pkg::*;

  localparam int W  = COORD_BITS;
  localparam int CW = (W > 32) ? W : 32;
  localparam logic signed [W-1:0]  WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [CW-1:0] CMAX = {{(CW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = ~CMAX;

  logic signed [W-1:0] cursor [AXES];
  logic signed [W-1:0] hw [AXES];
  logic signed [W-1:0] cursor_next [AXES];
  logic signed [W-1:0] hw_next [AXES];
  logic signed [W-1:0] start_c [AXES];
  logic signed [W-1:0] inc [AXES];
  logic signed [W-1:0] load_c;
  ax_act_t             act [AXES];
  logic                go;
  logic                is_eof;
  logic [W-1:0]        diff [AXES];
  logic [CW:0]         dz [AXES];
  logic signed [CW-1:0] ce [AXES];

  // start registers are 32-bit signed; clamp or sign-extend to coordinate width
  function automatic logic signed [W-1:0] clamp_start(input logic [31:0] s);
    logic signed [CW-1:0] se;
    logic signed [CW-1:0] cl;
    se = CW'($signed(s));
    if (se > CMAX) begin
      cl = CMAX;
    end else if (se < CMIN) begin
      cl = CMIN;
    end else begin
      cl = se;
    end
    return W'(cl);
  endfunction

  assign is_eof = (op.kind == OP_EOF);
  assign go     = op_valid && !res_full;
  assign op_pop = go;
  assign load_c = clamp_start(load.value);

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      act[a] = AX_HOLD;
    end
    unique case (op.kind)
      OP_ORD: begin
        act[0] = AX_BUMP;
      end
      OP_LINE: begin
        act[0] = AX_BACK;
        act[1] = AX_BUMP;
      end
      OP_FF: begin
        act[0] = AX_BACK;
        act[1] = AX_BACK;
        act[2] = AX_BUMP;
      end
      OP_VT: begin
        act[0] = AX_BACK;
        act[1] = AX_BACK;
        act[2] = AX_BACK;
        act[3] = AX_BUMP;
      end
      OP_EOF: begin
        for (int a = 0; a < AXES; a++) begin
          act[a] = AX_LOAD;
        end
      end
      default: begin
        for (int a = 0; a < AXES; a++) begin
          act[a] = AX_HOLD;
        end
      end
    endcase
  end

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      start_c[a]     = clamp_start(start[a]);
      inc[a]         = (cursor[a] != WMAX) ? cursor[a] + W'(1) : cursor[a];
      cursor_next[a] = cursor[a];
      hw_next[a]     = hw[a];
      if (load.valid && (load.axis == 2'(a))) begin
        cursor_next[a] = load_c;
        hw_next[a]     = load_c;
      end else if (go) begin
        case (act[a])
          AX_BUMP: begin
            cursor_next[a] = inc[a];
            if (inc[a] > hw[a]) hw_next[a] = inc[a];
          end
          AX_BACK: begin
            // cursor never exceeds high-water, so only the cursor moves
            cursor_next[a] = start_c[a];
          end
          AX_LOAD: begin
            cursor_next[a] = start_c[a];
            hw_next[a]     = start_c[a];
          end
          default: begin
            cursor_next[a] = cursor[a];
          end
        endcase
      end
    end
  end

  always_comb begin
    res_push  = go && (is_eof || ((op.kind == OP_ORD) && (op.value != CH_SP)));
    res.kind  = is_eof ? OUT_EXTENT : OUT_CELL;
    res.value = is_eof ? 8'd0 : op.value;
    for (int a = 0; a < AXES; a++) begin
      diff[a]       = hw[a] - start_c[a];
      dz[a]         = (CW+1)'(diff[a]);
      ce[a]         = CW'(cursor[a]);
      res.coord[a]  = is_eof ? 32'd0 : ce[a][31:0];
      if (!is_eof) begin
        res.extent[a] = 32'd0;
      end else if ((dz[a] >> 32) != '0) begin
        res.extent[a] = '1;
      end else begin
        res.extent[a] = dz[a][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < AXES; a++) begin
        cursor[a] <= '0;
        hw[a]     <= '0;
      end
    end else begin
      for (int a = 0; a < AXES; a++) begin
        cursor[a] <= cursor_next[a];
        hw[a]     <= hw_next[a];
      end
    end
  end

endmodule

>>> src/source_text_to_grid_loader_unit.sv
// Top level of the source text to grid loader: config registers, stages, queues.
//
//   channel   direction  handshake              payload
//   -------   ---------  ---------------------  ---------------------------------
//   input     in         push / full           kind, byte_value
//   result    out        empty / pop           out_kind, cell_x..w, cell_value,
//                                              extent_x..w
//   config    in         cfg_we (no wait)      cfg_index, cfg_data
//
// Sustained rate is one word per cycle on both sides while pop keeps the result
// queue from filling; a taken word is written into the op queue at the edge that
// takes it, and its result is then written into the result queue.
// The back stage's cursor update (one add and compare per axis) sets the pace.
// rst is synchronous; the block is ready the cycle after rst drops, no sweep.
// Stalls: pop held low fills the result queue, the back stage stops, then the
// op queue fills and full rises. Bytes that move nothing are dropped in front.
module source_text_to_grid_loader_unit #(
  parameter int COORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  // input words
  input  logic               push,
  output logic               full,
  input  logic               kind,
  input  logic [7:0]         byte_value,
  // result words
  output logic               empty,
  input  logic               pop,
  output logic               out_kind,
  output logic signed [31:0] cell_x,
  output logic signed [31:0] cell_y,
  output logic signed [31:0] cell_z,
  output logic signed [31:0] cell_w,
  output logic [7:0]         cell_value,
  output logic [31:0]        extent_x,
  output logic [31:0]        extent_y,
  output logic [31:0]        extent_z,
  output logic [31:0]        extent_w,
  // configuration writes
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import stgl_pkg::*;

  localparam int OP_W  = $bits(op_t);
  localparam int RES_W = $bits(res_t);

  // configuration registers
  logic [3:0][31:0] start;
  logic             binary_mode;
  logic [3:0]       dimension_count;
  start_load_t      load;

  // front to op queue
  logic             take;
  logic             op_push;
  op_t              op_in;
  logic             op_full;
  // op queue to back
  logic [OP_W-1:0]  op_bits;
  op_t              op_out;
  logic             op_empty;
  logic             op_pop;
  // back to result queue
  logic             res_push;
  res_t             res_in;
  logic             res_full;
  logic [RES_W-1:0] res_bits;
  res_t             res_out;

  assign full = op_full;
  assign take = push && !op_full;

  // start writes also reload that axis' cursor and high-water in the back stage
  always_comb begin
    load.valid = cfg_we && (cfg_index == REG_START_X || cfg_index == REG_START_Y ||
                            cfg_index == REG_START_Z || cfg_index == REG_START_W);
    load.axis  = cfg_index[1:0];
    load.value = cfg_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start           <= '0;
      binary_mode     <= 1'b0;
      dimension_count <= 4'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_X: start[0] <= cfg_data;
        REG_START_Y: start[1] <= cfg_data;
        REG_START_Z: start[2] <= cfg_data;
        REG_START_W: start[3] <= cfg_data;
        REG_BINARY:  binary_mode <= cfg_data[0];
        REG_DIMS:    dimension_count <= cfg_data[3:0];
        default: begin
          binary_mode <= binary_mode;
        end
      endcase
    end
  end

  stgl_front u_front (
    .clk             (clk),
    .rst             (rst),
    .take            (take),
    .kind            (kind),
    .byte_value      (byte_value),
    .binary_mode     (binary_mode),
    .dimension_count (dimension_count),
    .op_push         (op_push),
    .op              (op_in)
  );

  stgl_fifo #(
    .WIDTH (OP_W)
  ) u_op_q (
    .clk   (clk),
    .rst   (rst),
    .push  (op_push),
    .din   (op_in),
    .full  (op_full),
    .pop   (op_pop),
    .dout  (op_bits),
    .empty (op_empty)
  );

  assign op_out = op_t'(op_bits);

  stgl_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (!op_empty),
    .op       (op_out),
    .op_pop   (op_pop),
    .start    (start),
    .load     (load),
    .res_push (res_push),
    .res      (res_in),
    .res_full (res_full)
  );

  stgl_fifo #(
    .WIDTH (RES_W)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_bits),
    .empty (empty)
  );

  assign res_out    = res_t'(res_bits);
  assign out_kind   = res_out.kind;
  assign cell_x     = $signed(res_out.coord[0]);
  assign cell_y     = $signed(res_out.coord[1]);
  assign cell_z     = $signed(res_out.coord[2]);
  assign cell_w     = $signed(res_out.coord[3]);
  assign cell_value = res_out.value;
  assign extent_x   = res_out.extent[0];
  assign extent_y   = res_out.extent[1];
  assign extent_z   = res_out.extent[2];
  assign extent_w   = res_out.extent[3];

  // back stage never writes a word into a full result queue
  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result word pushed into full queue");

  // back stage only consumes an op that is present
  a_op_pop_valid: assert property (@(posedge clk) disable iff (rst)
    op_pop |-> !op_empty)
    else $error("op popped from empty queue");

  // result queue comes out of reset empty and the op queue not full
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not empty after reset");

endmodule
